// ----- rtl/assert_macros.svh -----
// Assertion macros shared by checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked implication checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- rtl/pool_pkg.sv -----
// Types and constants for the 2D mean/max pooling block.
// No dependencies.
`timescale 1ns / 1ps
package pool_pkg;
   localparam int MAX_WIDTH = 1024;

   localparam logic MODE_MEAN = 1'b0;
   localparam logic MODE_MAX  = 1'b1;

   localparam logic [2:0] REG_POOL_WIDTH   = 3'd0;
   localparam logic [2:0] REG_POOL_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_INPUT_WIDTH  = 3'd2;
   localparam logic [2:0] REG_INPUT_HEIGHT = 3'd3;
   localparam logic [2:0] REG_POOL_MODE    = 3'd4;
   localparam logic [2:0] REG_AREA_RECIP   = 3'd5;

   // Classified sample passed from front end to back end.
   typedef struct packed {
      logic signed [15:0] sample;
      logic               first;
      logic               last;
      logic               mode;
      logic [16:0]        recip;
      logic [9:0]         oc;
      logic [9:0]         orow;
      logic [11:0]        slice;
      logic [9:0]         col;
      logic [9:0]         row;
      logic               last_slice;
   } work_type;
endpackage

// ----- rtl/pool_front.sv -----
// Front end: position tracking and window classification.
// Depends on pool_pkg.
`timescale 1ns / 1ps
module pool_front #(
   parameter int MAX_POOL   = 8,
   parameter int MAX_SLICES = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [16:0]         csr_data,
   input  logic                in_valid,
   output logic                in_stall,
   input  logic signed [15:0]  in_sample,
   input  logic                in_frame_start,
   output logic                wk_valid,
   input  logic                wk_stall,
   output pool_pkg::work_type  wk_data
);
   localparam int CW = $clog2(pool_pkg::MAX_WIDTH + 1);
   localparam int PW = $clog2(MAX_POOL + 1);
   localparam int SW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;

   logic [3:0]  pw_ff, ph_ff;
   logic [10:0] iw_ff, ih_ff;
   logic        mode_ff;
   logic [16:0] recip_ff;

   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [PW-1:0] ciw_ff, ciw_in, riw_ff, riw_in;
   logic [SW-1:0] slc_ff, slc_in;

   logic [PW-1:0] pw, ph;
   logic [CW-1:0] iw, ih, ow, oh;
   logic [15:0]   pw_recip, ph_recip;
   logic [CW-1:0] c0, r0, oc0, or0;
   logic [PW-1:0] ci0, ri0;
   logic [SW-1:0] s0;
   logic          accept, inside_win, row_end, slice_end;

   pool_pkg::work_type wk_ff, wk_in;
   logic wk_valid_ff, wk_valid_in;

   // Scale for a window extent d: floor(n / d) = (n * scale) >> 15 for n below 2048.
   function automatic logic [15:0] extent_recip(input logic [3:0] d);
      logic [15:0] m;
      unique case (d)
         4'd2:    m = 16'd16384;
         4'd3:    m = 16'd10923;
         4'd4:    m = 16'd8192;
         4'd5:    m = 16'd6554;
         4'd6:    m = 16'd5462;
         4'd7:    m = 16'd4682;
         4'd8:    m = 16'd4096;
         4'd9:    m = 16'd3641;
         4'd10:   m = 16'd3277;
         4'd11:   m = 16'd2979;
         4'd12:   m = 16'd2731;
         4'd13:   m = 16'd2521;
         4'd14:   m = 16'd2341;
         4'd15:   m = 16'd2185;
         default: m = 16'd32768;
      endcase
      return m;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff <= 4'd2; ph_ff <= 4'd2; iw_ff <= 11'd1024; ih_ff <= 11'd1024;
         mode_ff <= pool_pkg::MODE_MAX; recip_ff <= 17'd16384;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pool_pkg::REG_POOL_WIDTH:   pw_ff <= csr_data[3:0];
            pool_pkg::REG_POOL_HEIGHT:  ph_ff <= csr_data[3:0];
            pool_pkg::REG_INPUT_WIDTH:  iw_ff <= csr_data[10:0];
            pool_pkg::REG_INPUT_HEIGHT: ih_ff <= csr_data[10:0];
            pool_pkg::REG_POOL_MODE:    mode_ff <= csr_data[0];
            pool_pkg::REG_AREA_RECIP:   recip_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      pw = (pw_ff == 4'd0) ? PW'(1) : (32'(pw_ff) > MAX_POOL) ? PW'(MAX_POOL) : PW'(pw_ff);
      ph = (ph_ff == 4'd0) ? PW'(1) : (32'(ph_ff) > MAX_POOL) ? PW'(MAX_POOL) : PW'(ph_ff);
      iw = (iw_ff == 11'd0) ? CW'(1) :
           (32'(iw_ff) > pool_pkg::MAX_WIDTH) ? CW'(pool_pkg::MAX_WIDTH) : CW'(iw_ff);
      ih = (ih_ff == 11'd0) ? CW'(1) :
           (32'(ih_ff) > pool_pkg::MAX_WIDTH) ? CW'(pool_pkg::MAX_WIDTH) : CW'(ih_ff);
      pw_recip = extent_recip(4'(pw));
      ph_recip = extent_recip(4'(ph));
      // Output extents by reciprocal multiply.
      ow = CW'((32'(iw) * 32'(pw_recip)) >> 15);
      oh = CW'((32'(ih) * 32'(ph_recip)) >> 15);
   end

   assign wk_valid = wk_valid_ff;
   assign wk_data  = wk_ff;
   assign in_stall = wk_valid_ff && wk_stall;
   assign accept   = in_valid && !in_stall;

   always_comb begin
      c0  = in_frame_start ? '0 : col_ff;
      r0  = in_frame_start ? '0 : row_ff;
      ci0 = in_frame_start ? '0 : ciw_ff;
      ri0 = in_frame_start ? '0 : riw_ff;
      s0  = in_frame_start ? '0 : slc_ff;
      oc0 = CW'((32'(c0) * 32'(pw_recip)) >> 15);
      or0 = CW'((32'(r0) * 32'(ph_recip)) >> 15);
      inside_win = (oc0 < ow) && (or0 < oh);
      row_end   = (32'(c0) + 1 >= 32'(iw));
      slice_end = row_end && (32'(r0) + 1 >= 32'(ih));

      wk_in.sample = in_sample;
      wk_in.first  = (ci0 == '0) && (ri0 == '0);
      wk_in.last   = (32'(ci0) + 1 >= 32'(pw)) && (32'(ri0) + 1 >= 32'(ph));
      wk_in.mode   = mode_ff;
      wk_in.recip  = recip_ff;
      wk_in.oc     = oc0[9:0];
      wk_in.orow   = or0[9:0];
      wk_in.slice  = 12'(s0);
      wk_in.col    = c0[9:0];
      wk_in.row    = r0[9:0];
      wk_in.last_slice = (32'(oc0) + 1 == 32'(ow)) && (32'(or0) + 1 == 32'(oh));

      col_in = c0; row_in = r0;
      ciw_in = ci0; riw_in = ri0; slc_in = s0;
      if (row_end) begin
         col_in = '0; ciw_in = '0;
         if (slice_end) begin
            row_in = '0; riw_in = '0;
            slc_in = (32'(s0) + 1 >= MAX_SLICES) ? '0 : SW'(32'(s0) + 1);
         end else begin
            row_in = r0 + 1'b1;
            if (32'(ri0) + 1 >= 32'(ph)) begin
               riw_in = '0;
            end else begin
               riw_in = ri0 + 1'b1;
            end
         end
      end else begin
         col_in = c0 + 1'b1;
         if (32'(ci0) + 1 >= 32'(pw)) begin
            ciw_in = '0;
         end else begin
            ciw_in = ci0 + 1'b1;
         end
      end
      wk_valid_in = wk_valid_ff && wk_stall;
      if (accept) wk_valid_in = inside_win;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0; row_ff <= '0;
         ciw_ff <= '0; riw_ff <= '0; slc_ff <= '0; wk_valid_ff <= 1'b0;
      end else begin
         wk_valid_ff <= wk_valid_in;
         if (accept) begin
            col_ff <= col_in; row_ff <= row_in;
            ciw_ff <= ciw_in; riw_ff <= riw_in; slc_ff <= slc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) wk_ff <= wk_in;
   end
endmodule

// ----- rtl/pool_back.sv -----
// Back end: per-column accumulator memory, scale and result register.
// Depends on pool_pkg.
`timescale 1ns / 1ps
module pool_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               wk_valid,
   output logic               wk_stall,
   input  pool_pkg::work_type wk_data,
   output logic               out_valid,
   input  logic               out_stall,
   output logic [15:0]        out_value,
   output logic [9:0]         out_col,
   output logic [9:0]         out_row,
   output logic [11:0]        out_slice,
   output logic [9:0]         out_peak_col,
   output logic [9:0]         out_peak_row,
   output logic               out_last
);
   localparam int AW = $clog2(pool_pkg::MAX_WIDTH);

   logic signed [23:0] acc_mem [pool_pkg::MAX_WIDTH];
   logic [9:0]         pc_mem  [pool_pkg::MAX_WIDTH];
   logic [9:0]         pr_mem  [pool_pkg::MAX_WIDTH];

   // Stage 1: read/update with forwarding from last write.
   logic               s1_valid_ff;
   pool_pkg::work_type s1_ff;
   logic signed [23:0] acc_rd_ff;
   logic [9:0]         pc_rd_ff, pr_rd_ff;
   logic               fwd_hit;
   logic signed [23:0] wr_acc_ff;
   logic [9:0]         wr_pc_ff, wr_pr_ff;
   logic [AW-1:0]      wr_addr_ff;
   logic               wr_en_ff;

   logic signed [23:0] base, acc_new;
   logic [9:0]         pc_new, pr_new;
   logic               s1_go, s2_free;

   // Stage 2: multiply product.
   logic               s2_valid_ff;
   pool_pkg::work_type s2_ff;
   logic signed [41:0] prod_ff;
   logic signed [23:0] max_ff;
   logic [9:0]         pc2_ff, pr2_ff;

   // Output register.
   logic        o_valid_ff;
   logic [15:0] o_val_ff;
   logic [9:0]  o_col_ff, o_row_ff, o_pc_ff, o_pr_ff;
   logic [11:0] o_slc_ff;
   logic        o_last_ff;
   logic signed [41:0] q;
   logic [15:0] v;

   logic [AW-1:0] rd_addr;
   assign rd_addr = wk_data.oc[AW-1:0];

   assign s2_free  = !o_valid_ff || !out_stall;
   assign s1_go    = !s2_valid_ff || s2_free;
   assign wk_stall = s1_valid_ff && !s1_go;

   // A write landing at the read edge is taken in place of the memory data;
   // a held stage 1 picks up a write that lands on its own entry.
   always_ff @(posedge clock) begin
      if (wk_valid && !wk_stall) begin
         if (wr_en_ff && wr_addr_ff == rd_addr) begin
            acc_rd_ff <= wr_acc_ff;
            pc_rd_ff  <= wr_pc_ff;
            pr_rd_ff  <= wr_pr_ff;
         end else begin
            acc_rd_ff <= acc_mem[rd_addr];
            pc_rd_ff  <= pc_mem[rd_addr];
            pr_rd_ff  <= pr_mem[rd_addr];
         end
         s1_ff     <= wk_data;
      end else if (wr_en_ff && wr_addr_ff == s1_ff.oc[AW-1:0]) begin
         acc_rd_ff <= wr_acc_ff;
         pc_rd_ff  <= wr_pc_ff;
         pr_rd_ff  <= wr_pr_ff;
      end
      if (wr_en_ff) begin
         acc_mem[wr_addr_ff] <= wr_acc_ff;
         pc_mem[wr_addr_ff]  <= wr_pc_ff;
         pr_mem[wr_addr_ff]  <= wr_pr_ff;
      end
   end

   always_comb begin
      fwd_hit = wr_en_ff && (wr_addr_ff == s1_ff.oc[AW-1:0]);
      base    = fwd_hit ? wr_acc_ff : acc_rd_ff;
      pc_new  = fwd_hit ? wr_pc_ff : pc_rd_ff;
      pr_new  = fwd_hit ? wr_pr_ff : pr_rd_ff;
      if (s1_ff.mode == pool_pkg::MODE_MEAN) begin
         acc_new = (s1_ff.first ? 24'sd0 : base) + 24'(s1_ff.sample);
      end else begin
         if (s1_ff.first) begin
            base = '0; pc_new = '0; pr_new = '0;
         end
         acc_new = base;
         if (24'(s1_ff.sample) > base) begin
            acc_new = 24'(s1_ff.sample); pc_new = s1_ff.col; pr_new = s1_ff.row;
         end
      end
   end

   // The write of stage 1 is registered before it lands in memory; forwarding covers that gap
   // and the memory read already returns older writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0; s2_valid_ff <= 1'b0; o_valid_ff <= 1'b0; wr_en_ff <= 1'b0;
      end else begin
         if (!wk_stall) s1_valid_ff <= wk_valid;
         wr_en_ff <= s1_valid_ff && s1_go;
         if (s1_go) s2_valid_ff <= s1_valid_ff && s1_ff.last;
         if (s2_free) o_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_go) begin
         wr_addr_ff <= s1_ff.oc[AW-1:0];
         wr_acc_ff  <= acc_new;
         wr_pc_ff   <= pc_new;
         wr_pr_ff   <= pr_new;
      end
      if (s1_go) begin
         s2_ff   <= s1_ff;
         prod_ff <= 42'(acc_new) * $signed({1'b0, s1_ff.recip});
         max_ff  <= acc_new;
         pc2_ff  <= pc_new;
         pr2_ff  <= pr_new;
      end
   end

   always_comb begin
      q = prod_ff >>> 16;
      if (s2_ff.mode == pool_pkg::MODE_MEAN) begin
         v = (q > 42'sd32767) ? 16'h7fff : (q < -42'sd32768) ? 16'h8000 : q[15:0];
      end else begin
         v = (max_ff > 24'sd32767) ? 16'h7fff : max_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && s2_valid_ff) begin
         o_val_ff <= v;
         o_col_ff <= s2_ff.oc; o_row_ff <= s2_ff.orow; o_slc_ff <= s2_ff.slice;
         o_pc_ff  <= (s2_ff.mode == pool_pkg::MODE_MAX) ? pc2_ff : 10'd0;
         o_pr_ff  <= (s2_ff.mode == pool_pkg::MODE_MAX) ? pr2_ff : 10'd0;
         o_last_ff <= s2_ff.last_slice;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_value = o_val_ff;
   assign out_col = o_col_ff;
   assign out_row = o_row_ff;
   assign out_slice = o_slc_ff;
   assign out_peak_col = o_pc_ff;
   assign out_peak_row = o_pr_ff;
   assign out_last = o_last_ff;
endmodule

// ----- rtl/pool_2d_mean_max_top.sv -----
// Top level of the 2D mean/max pooling block.
// Depends on pool_pkg, pool_front and pool_back.
// Usage:
//   req_ channel: one Q8.8 sample per transaction, column fastest; req_frame_start
//   restarts all position counters before the sample is taken.
//   rsp_ channel: one result per completed window, on its last sample.
//   csr_ port: write registers 0..5 only while the block is idle.
//   Throughput: one sample per cycle while req_stall is low, sustained by the read-modify-write
//   of the per-column accumulator memory (with write forwarding).
//   Path: a window's last sample passes the front-end work register, stage 1, stage 2 and the result register.
//   Reset clears counters and the pipeline; accumulator memory needs no clearing,
//   as every window starts with a write on its first sample.
//   A rsp_stall holds the result register; the front end and pipeline keep
//   accepting until their stages fill, then assert req_stall.
`timescale 1ns / 1ps
module pool_2d_mean_max_top #(
   parameter int MAX_POOL   = 8,
   parameter int MAX_SLICES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [15:0] req_sample_value,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_pooled_value,
   output logic [9:0]  rsp_out_col,
   output logic [9:0]  rsp_out_row,
   output logic [11:0] rsp_slice_index,
   output logic [9:0]  rsp_peak_col,
   output logic [9:0]  rsp_peak_row,
   output logic        rsp_last_of_slice
);
   logic               wk_valid, wk_stall;
   pool_pkg::work_type wk_data;
   logic [15:0]        value;

   pool_front #(.MAX_POOL(MAX_POOL), .MAX_SLICES(MAX_SLICES)) u_front (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_data,
      .in_valid(req_valid), .in_stall(req_stall), .in_sample(req_sample_value),
      .in_frame_start(req_frame_start),
      .wk_valid, .wk_stall, .wk_data
   );

   pool_back u_back (
      .clock, .reset, .wk_valid, .wk_stall, .wk_data,
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_value(value),
      .out_col(rsp_out_col), .out_row(rsp_out_row), .out_slice(rsp_slice_index),
      .out_peak_col(rsp_peak_col), .out_peak_row(rsp_peak_row),
      .out_last(rsp_last_of_slice)
   );

   assign rsp_pooled_value = $signed(value);
endmodule

// ----- rtl/pool_checker.sv -----
// Port-level checker for the pooling block, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pool_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_pooled_value
);
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp dropped")
   `ASSERT_CLK(a_val_hold, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_pooled_value), "rsp changed")
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "rsp valid after reset")
   `ASSERT_CLK(a_stall_full, clock, reset, req_stall |-> rsp_valid && rsp_stall || $past(rsp_stall), "req stall without backpressure")
endmodule

bind pool_2d_mean_max_top pool_checker u_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_pooled_value
);

// ----- sim/tb.sv -----
// Testbench for pool_2d_mean_max_top: streams samples through phases of register settings,
// predicts each pooled window in the bench and compares every rsp_ transaction field by field.
// Depends on pool_pkg and the pool_2d_mean_max_top RTL.
`timescale 1ns / 1ps
module tb;
   typedef struct {
      logic signed [15:0] sample;
      logic               frame_start;
   } sample_type;

   typedef struct {
      logic signed [15:0] pooled;
      logic [9:0]         out_col;
      logic [9:0]         out_row;
      logic [11:0]        slice;
      logic [9:0]         peak_col;
      logic [9:0]         peak_row;
      logic               last_of_slice;
   } window_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [2:0] csr_index = pool_pkg::REG_POOL_WIDTH;
   logic [16:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_sample_value = '0;
   logic req_frame_start = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_pooled_value;
   logic [9:0] rsp_out_col, rsp_out_row, rsp_peak_col, rsp_peak_row;
   logic [11:0] rsp_slice_index;
   logic rsp_last_of_slice;

   pool_2d_mean_max_top DUT (.*);

   always #1 clock = ~clock;

   sample_type        pending_samples[$];
   window_result_type expected_windows[$];
   int  errors = 0;
   int  accepted = 0;
   int  cycles = 0;
   int  send_idle_pct = 14;
   int  recv_stall_pct = 46;

   // register shadow and predictor state
   logic [3:0]  cfg_pool_w = 4'd2, cfg_pool_h = 4'd2;
   logic [10:0] cfg_in_w = 11'd1024, cfg_in_h = 11'd1024;
   logic        cfg_mode = pool_pkg::MODE_MAX;
   logic [16:0] cfg_recip = 17'd16384;
   logic signed [23:0] win_sum [1024];
   logic [9:0]  win_peak_col [1024];
   logic [9:0]  win_peak_row [1024];
   int col_cnt = 0, row_cnt = 0, slice_cnt = 0, row_in_win = 0, col_in_win = 0;

   function automatic int clamp_size(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic predict_window(input logic signed [15:0] x, input logic fs);
      int pw, ph, iw, ih, ow, oh, oc, orow;
      bit first, last, row_end;
      longint prod, q;
      window_result_type r;
      pw = clamp_size(cfg_pool_w, 8);
      ph = clamp_size(cfg_pool_h, 8);
      iw = clamp_size(cfg_in_w, 1024);
      ih = clamp_size(cfg_in_h, 1024);
      ow = iw / pw;
      oh = ih / ph;
      if (fs) begin
         col_cnt = 0; row_cnt = 0; slice_cnt = 0; row_in_win = 0; col_in_win = 0;
      end
      oc = col_cnt / pw;
      orow = row_cnt / ph;
      if (oc < ow && orow < oh) begin
         first = (col_in_win == 0 && row_in_win == 0);
         last = (col_in_win + 1 >= pw && row_in_win + 1 >= ph);
         if (cfg_mode == pool_pkg::MODE_MEAN) begin
            win_sum[oc] = (first ? 24'sd0 : win_sum[oc]) + 24'(x);
         end else begin
            if (first) begin
               win_sum[oc] = '0; win_peak_col[oc] = '0; win_peak_row[oc] = '0;
            end
            if (24'(x) > win_sum[oc]) begin
               win_sum[oc] = 24'(x);
               win_peak_col[oc] = 10'(col_cnt);
               win_peak_row[oc] = 10'(row_cnt);
            end
         end
         if (last) begin
            r.peak_col = '0;
            r.peak_row = '0;
            if (cfg_mode == pool_pkg::MODE_MEAN) begin
               prod = longint'(win_sum[oc]) * longint'({1'b0, cfg_recip});
               if (prod >= 0) q = prod >>> 16;
               else q = -((-prod + 65535) >>> 16);
               if (q > 32767) q = 32767;
               if (q < -32768) q = -32768;
               r.pooled = q[15:0];
            end else begin
               if (win_sum[oc] > 24'sd32767) r.pooled = 16'sh7fff;
               else if (win_sum[oc] < -24'sd32768) r.pooled = 16'sh8000;
               else r.pooled = win_sum[oc][15:0];
               r.peak_col = win_peak_col[oc];
               r.peak_row = win_peak_row[oc];
            end
            r.out_col = 10'(oc);
            r.out_row = 10'(orow);
            r.slice = 12'(slice_cnt);
            r.last_of_slice = (oc + 1 == ow && orow + 1 == oh);
            expected_windows.push_back(r);
         end
      end
      row_end = (col_cnt + 1 >= iw);
      if (row_end) begin
         col_cnt = 0;
         col_in_win = 0;
         if (row_cnt + 1 >= ih) begin
            row_cnt = 0;
            row_in_win = 0;
            slice_cnt = (slice_cnt + 1 >= 4096) ? 0 : slice_cnt + 1;
         end else begin
            row_cnt++;
            row_in_win = (row_in_win + 1 >= ph) ? 0 : row_in_win + 1;
         end
      end else begin
         col_cnt++;
         col_in_win = (col_in_win + 1 >= pw) ? 0 : col_in_win + 1;
      end
   endtask

   // driver: hold a stalled transaction, otherwise advance or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_window(req_sample_value, req_frame_start);
            accepted++;
            if (accepted < 600) begin
               send_idle_pct = 14; recv_stall_pct = 46;
            end else if (accepted < 1200) begin
               send_idle_pct = 46; recv_stall_pct = 14;
            end else begin
               send_idle_pct = 0; recv_stall_pct = 0;
            end
         end
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_sample_value <= pending_samples[0].sample;
               req_frame_start <= pending_samples[0].frame_start;
               void'(pending_samples.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      window_result_type e;
      cycles++;
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_windows.size() == 0) begin
            $display("%0t: unexpected result pooled=%0d col=%0d row=%0d", $time,
                     rsp_pooled_value, rsp_out_col, rsp_out_row);
            errors++;
         end else begin
            e = expected_windows.pop_front();
            if (rsp_pooled_value !== e.pooled) begin
               $display("%0t: pooled_value expected %0d actual %0d", $time, e.pooled,
                        rsp_pooled_value);
               errors++;
            end
            if (rsp_out_col !== e.out_col) begin
               $display("%0t: out_col expected %0d actual %0d", $time, e.out_col, rsp_out_col);
               errors++;
            end
            if (rsp_out_row !== e.out_row) begin
               $display("%0t: out_row expected %0d actual %0d", $time, e.out_row, rsp_out_row);
               errors++;
            end
            if (rsp_slice_index !== e.slice) begin
               $display("%0t: slice_index expected %0d actual %0d", $time, e.slice,
                        rsp_slice_index);
               errors++;
            end
            if (rsp_peak_col !== e.peak_col) begin
               $display("%0t: peak_col expected %0d actual %0d", $time, e.peak_col,
                        rsp_peak_col);
               errors++;
            end
            if (rsp_peak_row !== e.peak_row) begin
               $display("%0t: peak_row expected %0d actual %0d", $time, e.peak_row,
                        rsp_peak_row);
               errors++;
            end
            if (rsp_last_of_slice !== e.last_of_slice) begin
               $display("%0t: last_of_slice expected %0d actual %0d", $time,
                        e.last_of_slice, rsp_last_of_slice);
               errors++;
            end
         end
      end
      if (cycles > 300000) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_samples.size() > 0 || req_valid || expected_windows.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [16:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         pool_pkg::REG_POOL_WIDTH:   cfg_pool_w = value[3:0];
         pool_pkg::REG_POOL_HEIGHT:  cfg_pool_h = value[3:0];
         pool_pkg::REG_INPUT_WIDTH:  cfg_in_w = value[10:0];
         pool_pkg::REG_INPUT_HEIGHT: cfg_in_h = value[10:0];
         pool_pkg::REG_POOL_MODE:    cfg_mode = value[0];
         pool_pkg::REG_AREA_RECIP:   cfg_recip = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(input int pw, input int ph, input int iw, input int ih,
                            input logic mode, input int recip);
      wait_drained();
      write_reg(pool_pkg::REG_POOL_WIDTH, 17'(pw));
      write_reg(pool_pkg::REG_POOL_HEIGHT, 17'(ph));
      write_reg(pool_pkg::REG_INPUT_WIDTH, 17'(iw));
      write_reg(pool_pkg::REG_INPUT_HEIGHT, 17'(ih));
      write_reg(pool_pkg::REG_POOL_MODE, 17'(mode));
      write_reg(pool_pkg::REG_AREA_RECIP, 17'(recip));
   endtask

   task automatic push_sample(input logic signed [15:0] s, input logic fs);
      sample_type t;
      t.sample = s;
      t.frame_start = fs;
      pending_samples.push_back(t);
   endtask

   task automatic push_random(input int n, input int fs_pct);
      for (int i = 0; i < n; i++)
         push_sample(16'($urandom), (i == 0) || ($urandom_range(99) < fs_pct));
   endtask

   initial begin
      logic signed [15:0] max_vals [8] = '{32767, -32768, -1, -5, 1, 32767, -32768, 0};
      logic signed [15:0] mean_vals [8] = '{32767, 32767, -32768, -32768,
                                            32767, 32767, -32768, -32768};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // directed: peak ties, all non-positive window, mean saturation both ways
      configure(2, 2, 4, 2, pool_pkg::MODE_MAX, 16384);
      foreach (max_vals[i]) push_sample(max_vals[i], i == 0);
      configure(2, 2, 4, 2, pool_pkg::MODE_MEAN, 131071);
      foreach (mean_vals[i]) push_sample(mean_vals[i], i == 0);
      push_sample(16'sd256, 1'b1);
      push_sample(-16'sd256, 1'b0);
      // random phases
      configure(3, 2, 10, 5, pool_pkg::MODE_MAX, 0);
      push_random(200, 1);
      configure(2, 3, 7, 7, pool_pkg::MODE_MEAN, 10923);
      push_random(200, 1);
      configure(0, 15, 3, 17, pool_pkg::MODE_MAX, 65536);
      push_random(200, 1);
      configure(8, 8, 17, 16, pool_pkg::MODE_MEAN, 1024);
      push_random(180, 0);
      configure(1, 1, 2047, 0, pool_pkg::MODE_MEAN, 131071);
      push_random(150, 2);
      configure(2, 1, 4, 3, pool_pkg::MODE_MEAN, 0);
      push_random(60, 2);
      configure(8, 8, 5, 5, pool_pkg::MODE_MAX, 16384);
      push_random(40, 2);
      for (int k = 0; k < 3; k++) begin
         configure($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 40),
                   $urandom_range(1, 40), 1'($urandom_range(1)), $urandom_range(131071));
         push_random(100, 1);
      end
      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pool_pkg.sv
rtl/pool_front.sv
rtl/pool_back.sv
rtl/pool_2d_mean_max_top.sv
rtl/pool_checker.sv
sim/tb.sv
